[hdl/u8col_pkg.sv]
`timescale 1ns / 1ps
// u8col_pkg: shared constants and types for the UTF-8 offset to line/column block.
// No dependencies.
package u8col_pkg;

   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_TARGET_OFFSET = 3'd0;

   // summary of one item's scan, handed from the step logic to the counters
   typedef struct packed {
      logic       stop;       // scan has reached its end point
      logic [2:0] consumed;   // bytes retired from the window
      logic [2:0] fill_next;  // bytes left in the window
      logic [2:0] lines_add;  // newlines retired
      logic       unit_clr;   // column restarts (a newline was retired)
      logic [2:0] units_add;  // UTF-16 units since the last clear or the old column
   } scan_ctl_type;

endpackage

[hdl/u8col_step.sv]
`timescale 1ns / 1ps
// u8col_step: per-item scan of the four-byte look-ahead window.
// Depends on u8col_pkg.
module u8col_step import u8col_pkg::*; (
   input  logic [3:0][7:0] pending,
   input  logic [2:0]      fill,
   input  logic            stopped,
   input  logic [7:0]      data_byte,
   input  logic            last,
   input  logic [2:0]      room,        // distance to target, saturated at 7
   output logic [3:0][7:0] pending_next,
   output scan_ctl_type    ctl
);

   typedef struct packed {
      logic       lf;
      logic       cr;
      logic       wait_more;
      logic [2:0] len;
      logic [1:0] units;
   } seq_info_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & 8'hC0) == 8'h80;
   endfunction

   function automatic seq_info_type classify(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] avail, input logic at_end);
      seq_info_type r;
      logic         lead2;
      logic         lead3;
      logic         lead4;
      logic [2:0]   need;
      lead2 = (b0 & 8'hE0) == 8'hC0;
      lead3 = (b0 & 8'hF0) == 8'hE0;
      lead4 = (b0 & 8'hF8) == 8'hF0;
      need  = lead2 ? 3'd2 : lead3 ? 3'd3 : lead4 ? 3'd4 : 3'd1;
      r.lf  = b0 == BYTE_LF;
      r.cr  = b0 == BYTE_CR;
      r.wait_more = !at_end && (avail < need);
      if (b0 < 8'h80) begin
         r.len = 3'd1;
      end else if (lead2 && avail >= 3'd2 && is_cont(b1)) begin
         r.len = 3'd2;
      end else if (lead3 && avail >= 3'd3 && is_cont(b1) && is_cont(b2)) begin
         r.len = 3'd3;
      end else if (lead4 && avail >= 3'd4 && is_cont(b1) && is_cont(b2) && is_cont(b3)) begin
         r.len = 3'd4;
      end else begin
         r.len = 3'd1;
      end
      // four-byte value reaches 0x10000 when any of its top five bits is set
      r.units = (r.len == 3'd4 && ((b0 & 8'h07) != 8'h00 || b1[5:4] != 2'b00)) ? 2'd2 : 2'd1;
      return r;
   endfunction

   logic            append;
   logic [2:0]      n;
   logic [7:0][7:0] ext;
   seq_info_type    info [4];

   always_comb begin
      append = !stopped && !fill[2];
      n      = fill + {2'b00, append};
      ext    = {32'h0, pending};
      if (append) begin
         ext[fill[1:0]] = data_byte;
      end
   end

   always_comb begin
      for (int s = 0; s < 4; s++) begin
         info[s] = classify(ext[s], ext[s+1], ext[s+2], ext[s+3],
                            (n > 3'(s)) ? n - 3'(s) : 3'd0, last);
      end
   end

   logic [2:0]   p;
   logic         halt;
   logic         stop;
   logic [2:0]   lines;
   logic         clr;
   logic [2:0]   ua;
   logic [3:0]   seq_end;
   seq_info_type cur;

   always_comb begin
      p       = 3'd0;
      halt    = stopped;
      stop    = stopped;
      lines   = 3'd0;
      clr     = 1'b0;
      ua      = 3'd0;
      seq_end = 4'd0;
      cur     = info[0];
      for (int i = 0; i < 4; i++) begin
         if (!halt && p < n) begin
            cur     = info[p[1:0]];
            seq_end = {1'b0, p} + {1'b0, cur.len};
            if (p >= room) begin
               stop = 1'b1;
               halt = 1'b1;
            end else if (cur.lf) begin
               lines = lines + 3'd1;
               clr   = 1'b1;
               ua    = 3'd0;
               p     = p + 3'd1;
            end else if (cur.cr) begin
               p = p + 3'd1;
            end else if (cur.wait_more) begin
               halt = 1'b1;
            end else if (seq_end > {1'b0, room}) begin
               stop = 1'b1;
               halt = 1'b1;
            end else begin
               ua = ua + {1'b0, cur.units};
               p  = seq_end[2:0];
            end
         end
      end
   end

   always_comb begin
      unique case (p)
         3'd0:    pending_next = ext[3:0];
         3'd1:    pending_next = ext[4:1];
         3'd2:    pending_next = ext[5:2];
         3'd3:    pending_next = ext[6:3];
         default: pending_next = ext[7:4];
      endcase
      ctl.stop      = stop;
      ctl.consumed  = p;
      ctl.fill_next = n - p;
      ctl.lines_add = lines;
      ctl.unit_clr  = clr;
      ctl.units_add = ua;
   end

endmodule

[hdl/utf8_offset_to_line_utf16_column_core.sv]
`timescale 1ns / 1ps
// utf8_offset_to_line_utf16_column_core: top level, counters, CSR port, result register.
// Depends on u8col_pkg and u8col_step.
//
// Usage:
//   req_*  carries the UTF-8 text, one byte per item, req_tlast on the final byte.
//   rsp_*  carries one item per text: (line, UTF-16 column) of the byte offset held in
//          the target register, both zero-based.
//   csr_*  APB-style port; register 0 at address 0 is the target offset.
// Timing:
//   Every byte is scanned in the cycle it is accepted; one byte per cycle is sustained.
//   The result is registered and appears on rsp in the cycle after the last byte is accepted.
//   The result register is the only buffer: req_tready drops only while a result
//   waits and rsp_tready is low.
// Reset:
//   Synchronous, active high. Clears the target to zero and starts a new text.
//   After each last byte the scan state returns to its start for the next text.
module utf8_offset_to_line_utf16_column_core import u8col_pkg::*; #(
   parameter int unsigned OFFSET_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] data_byte
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,   // [23:0] line, [47:24] column_units
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [OFFSET_BITS-1:0] target_ff, target_in;
   logic [OFFSET_BITS-1:0] byte_index_ff, byte_index_in;
   logic [OFFSET_BITS-1:0] line_ff, line_in;
   logic [OFFSET_BITS-1:0] unit_ff, unit_in;
   logic [3:0][7:0]        pending_ff, pending_in;
   logic [2:0]             fill_ff, fill_in;
   logic                   stopped_ff, stopped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [23:0]            rsp_line_ff, rsp_line_in;
   logic [23:0]            rsp_unit_ff, rsp_unit_in;

   logic                   accept;
   logic                   csr_write;
   logic [OFFSET_BITS+31:0] wdata_ext;
   logic [OFFSET_BITS+31:0] target_ext;
   logic [OFFSET_BITS:0]   to_go;
   logic [2:0]             room;
   logic [3:0][7:0]        pending_next;
   scan_ctl_type           ctl;
   logic [OFFSET_BITS-1:0] line_next;
   logic [OFFSET_BITS-1:0] unit_next;
   logic [OFFSET_BITS+23:0] line_ext;
   logic [OFFSET_BITS+23:0] unit_ext;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata_ext  = {{OFFSET_BITS{1'b0}}, csr_pwdata};
   assign target_ext = {32'h0, target_ff};
   assign target_in  = (csr_write && csr_paddr == REG_TARGET_OFFSET) ?
                       wdata_ext[OFFSET_BITS-1:0] : target_ff;
   assign csr_prdata = (csr_paddr == REG_TARGET_OFFSET) ? target_ext[31:0] : 32'h0;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // bytes still to go before the target, saturated to what one item can use
   always_comb begin
      to_go = {1'b0, target_ff} - {1'b0, byte_index_ff};
      if (to_go[OFFSET_BITS]) begin
         room = 3'd0;
      end else if (to_go[OFFSET_BITS-1:3] != '0) begin
         room = 3'd7;
      end else begin
         room = to_go[2:0];
      end
   end

   u8col_step u_step (
      .pending      (pending_ff),
      .fill         (fill_ff),
      .stopped      (stopped_ff),
      .data_byte    (req_tdata),
      .last         (req_tlast),
      .room         (room),
      .pending_next (pending_next),
      .ctl          (ctl)
   );

   always_comb begin
      line_next = line_ff + OFFSET_BITS'(ctl.lines_add);
      unit_next = ctl.unit_clr ? OFFSET_BITS'(ctl.units_add)
                               : unit_ff + OFFSET_BITS'(ctl.units_add);
      line_ext  = {24'h0, line_next};
      unit_ext  = {24'h0, unit_next};

      byte_index_in = byte_index_ff;
      line_in       = line_ff;
      unit_in       = unit_ff;
      pending_in    = pending_ff;
      fill_in       = fill_ff;
      stopped_in    = stopped_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_unit_in   = rsp_unit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         pending_in = pending_next;
         if (req_tlast) begin
            byte_index_in = '0;
            line_in       = '0;
            unit_in       = '0;
            fill_in       = 3'd0;
            stopped_in    = 1'b0;
            rsp_line_in   = line_ext[23:0];
            rsp_unit_in   = unit_ext[23:0];
            rsp_valid_in  = 1'b1;
         end else begin
            byte_index_in = byte_index_ff + OFFSET_BITS'(ctl.consumed);
            line_in       = line_next;
            unit_in       = unit_next;
            fill_in       = ctl.fill_next;
            stopped_in    = ctl.stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         byte_index_ff <= '0;
         line_ff       <= '0;
         unit_ff       <= '0;
         fill_ff       <= 3'd0;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         byte_index_ff <= byte_index_in;
         line_ff       <= line_in;
         unit_ff       <= unit_in;
         fill_ff       <= fill_in;
         stopped_ff    <= stopped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff  <= pending_in;
      rsp_line_ff <= rsp_line_in;
      rsp_unit_ff <= rsp_unit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_unit_ff, rsp_line_ff};

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> rsp_tvalid)
      else $error("last item did not produce a result");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && !(rsp_valid_ff && !rsp_tready)) |=> !rsp_tvalid)
      else $error("result without a last item");

   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      !stopped_ff |-> (fill_ff < 3'd4))
      else $error("look-ahead window full while scanning");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (fill_ff == 3'd0 && !stopped_ff && byte_index_ff == '0))
      else $error("scan state not cleared after last item");

endmodule

[test/tb_utf8_offset_to_line_utf16_column_core.sv]
`timescale 1ns / 1ps
// tb_utf8_offset_to_line_utf16_column_core: self-checking bench for the UTF-8 offset to
// (line, UTF-16 column) block. Needs u8col_pkg and utf8_offset_to_line_utf16_column_core.
// Directed texts first, then random texts under several target offsets, checked in order.
module tb_utf8_offset_to_line_utf16_column_core;
   import u8col_pkg::*;

   typedef struct packed {
      logic [23:0] col;
      logic [23:0] line;
   } position_type;

   typedef struct packed {
      bit           known;
      position_type pos;
   } typed_pos_type;

   typedef struct packed {
      bit          set_tgt;
      logic [23:0] tgt;
      logic [7:0]  data;
      bit          last;
      bit          known;
      logic [23:0] line;
      logic [23:0] col;
   } dir_row_type;

   localparam int DIR_ROWS = 27;
   localparam int ITEM_TARGET = 600;
   localparam int HOLD_CYCLES = 250;

   localparam dir_row_type DIRECTED [0:DIR_ROWS-1] = '{
      // target left at its reset value of zero
      '{1'b0, 24'd0,        8'h41, 1'b1, 1'b1, 24'd0, 24'd0},
      // 2-byte, newline, carriage return, bad lead
      '{1'b1, 24'hFFFFFF,   8'hC3, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hA9, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h0A, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h0D, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hFF, 1'b1, 1'b1, 24'd1, 24'd1},
      // 3-byte then a supplementary-plane 4-byte
      '{1'b0, 24'd0,        8'hE2, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h82, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hAC, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hF0, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h9F, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h98, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h80, 1'b1, 1'b0, 24'd0, 24'd0},
      // overlong 4-byte, then one above 0x10FFFF
      '{1'b0, 24'd0,        8'hF0, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h80, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h80, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h80, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hF7, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hBF, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hBF, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hBF, 1'b1, 1'b1, 24'd0, 24'd3},
      // 3-byte lead cut short by a plain byte at the end of text
      '{1'b0, 24'd0,        8'hE2, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h41, 1'b1, 1'b1, 24'd0, 24'd2},
      // sequence straddling the target, trailing bytes ignored
      '{1'b1, 24'd2,        8'h41, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hE2, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'h82, 1'b0, 1'b0, 24'd0, 24'd0},
      '{1'b0, 24'd0,        8'hAC, 1'b1, 1'b1, 24'd0, 24'd1}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // [7:0] data_byte
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [47:0]              rsp_tdata;   // [23:0] line, [47:24] column_units
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   utf8_offset_to_line_utf16_column_core dut (.*);

   // scanner model state
   logic [23:0]  target_ofs;
   int unsigned  scan_pos;
   logic [23:0]  line_acc;
   logic [23:0]  col_acc;
   logic [7:0]   win [4];
   int unsigned  win_fill;
   bit           halted;

   position_type  pending_positions [$];
   typed_pos_type typed_positions [$];
   int           fault_count;
   int           results_seen;
   int           texts_sent;
   int           items_sent;
   int           burst_left;

   function automatic int unsigned lead_need(input logic [7:0] f);
      casez (f)
         8'b110?????: return 2;
         8'b1110????: return 3;
         8'b11110???: return 4;
         default:     return 1;
      endcase
   endfunction

   function automatic bit is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic int unsigned seq_len();
      int unsigned need;
      int unsigned k;
      need = lead_need(win[0]);
      if (win[0][7] == 1'b0 || need == 1 || win_fill < need) return 1;
      for (k = 1; k < need; k++)
         if (!is_cont(win[k])) return 1;
      return need;
   endfunction

   function automatic void retire(input int unsigned n);
      int k;
      if (n > win_fill) n = win_fill;
      for (k = 0; k < 4; k++)
         win[k] = (k + n < 4) ? win[k + n] : 8'h00;
      win_fill -= n;
      scan_pos += n;
   endfunction

   function automatic void clear_scan();
      scan_pos = 0;
      line_acc = '0;
      col_acc  = '0;
      win_fill = 0;
      halted   = 1'b0;
      foreach (win[k]) win[k] = 8'h00;
   endfunction

   function automatic void advance_scan(input bit at_end);
      logic [7:0]  f;
      int unsigned n;
      logic [20:0] cp;
      while (win_fill > 0 && !halted) begin
         f = win[0];
         if (scan_pos >= target_ofs) begin
            halted = 1'b1;
            break;
         end
         if (f == BYTE_LF) begin
            line_acc = line_acc + 24'd1;
            col_acc = '0;
            retire(1);
            continue;
         end
         if (f == BYTE_CR) begin
            retire(1);
            continue;
         end
         if (!at_end && win_fill < lead_need(f)) break;
         n = seq_len();
         if (scan_pos + n > target_ofs) begin
            halted = 1'b1;
            break;
         end
         cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
         if (n == 4 && cp >= 21'h10000) col_acc = col_acc + 24'd2;
         else col_acc = col_acc + 24'd1;
         retire(n);
      end
   endfunction

   function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
                                      output position_type res);
      if (!halted && win_fill < 4) begin
         win[win_fill] = b;
         win_fill++;
      end
      advance_scan(fin);
      res.line = line_acc;
      res.col  = col_acc;
      if (fin) clear_scan();
      return fin;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_utf8_offset_to_line_utf16_column_core: done, errors");
      $finish;
   end

   always @(posedge clock) begin : watch
      position_type  got;
      position_type  want;
      typed_pos_type typed;
      if (reset) begin
         clear_scan();
         target_ofs = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = rsp_tdata;
            if (pending_positions.size() == 0) begin
               $display("%0t: unexpected result line %0d col %0d", $time, got.line, got.col);
               fault_count++;
            end else begin
               want = pending_positions.pop_front();
               if (got.line !== want.line) begin
                  $display("%0t: line expected %0d, got %0d", $time, want.line, got.line);
                  fault_count++;
               end
               if (got.col !== want.col) begin
                  $display("%0t: column expected %0d, got %0d", $time, want.col, got.col);
                  fault_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (absorb_byte(req_tdata, req_tlast, want)) begin
               if (typed_positions.size() != 0) begin
                  typed = typed_positions.pop_front();
                  if (typed.known) want = typed.pos;
               end
               pending_positions.push_back(want);
            end
         end
      end
   end

   // receiver: mixes always-ready, random and fixed stall patterns, plus two long hold-offs
   initial begin : receiver
      int mode;
      int span;
      int tick;
      int holds_left;
      int hold_mark;
      holds_left = 2;
      hold_mark = 8;
      tick = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 90);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (holds_left > 0 && results_seen >= hold_mark) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               holds_left--;
               hold_mark += 25;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= (tick % 5) < 2;
               endcase
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (fin) texts_sent++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_seen != texts_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= REG_TARGET_OFFSET;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_target(input logic [23:0] v);
      logic [31:0] wdata;
      logic [31:0] rdata;
      wdata = $urandom;
      wdata[23:0] = v;
      csr_access(1'b1, wdata, rdata);
      target_ofs = v;
      @(posedge clock);
      csr_access(1'b0, 32'd0, rdata);
      if (rdata[23:0] !== v) begin
         $display("%0t: target readback expected %0d, got %0d", $time, v, rdata[23:0]);
         fault_count++;
      end
   endtask

   // mostly well-formed UTF-8 with random content; noise and broken sequences mixed in
   task automatic send_text();
      logic [7:0] txt [$];
      logic [7:0] seq [4];
      int         len;
      int         nb;
      int         kind;
      int         k;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      while (txt.size() < len) begin
         kind = $urandom_range(0, 99);
         for (k = 1; k < 4; k++) seq[k] = {2'b10, 6'($urandom)};
         if (kind < 38) begin
            seq[0] = 8'($urandom_range(0, 127));
            nb = 1;
         end else if (kind < 46) begin
            seq[0] = BYTE_LF;
            nb = 1;
         end else if (kind < 50) begin
            seq[0] = BYTE_CR;
            nb = 1;
         end else if (kind < 60) begin
            seq[0] = {3'b110, 5'($urandom)};
            nb = 2;
         end else if (kind < 70) begin
            seq[0] = {4'b1110, 4'($urandom)};
            nb = 3;
         end else if (kind < 84) begin
            seq[0] = {5'b11110, 3'($urandom)};
            nb = 4;
         end else if (kind < 92) begin
            seq[0] = 8'($urandom_range(0, 255));
            nb = 1;
         end else begin
            nb = $urandom_range(2, 4);
            seq[0] = (nb == 2) ? {3'b110, 5'($urandom)} :
                     (nb == 3) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)};
            nb = $urandom_range(1, nb - 1);
         end
         for (k = 0; k < nb; k++)
            if (txt.size() < len) txt.push_back(seq[k]);
      end
      for (k = 0; k < len; k++)
         push_byte(txt[k], k == len - 1);
   endtask

   initial begin : stimulus
      int            phase;
      int            pick;
      logic [23:0]   tgt;
      typed_pos_type typed;
      fault_count  = 0;
      results_seen = 0;
      texts_sent   = 0;
      items_sent   = 0;
      burst_left   = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'h00;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].set_tgt) begin
            settle();
            program_target(DIRECTED[i].tgt);
         end
         if (DIRECTED[i].last) begin
            typed.known    = DIRECTED[i].known;
            typed.pos.line = DIRECTED[i].line;
            typed.pos.col  = DIRECTED[i].col;
            typed_positions.push_back(typed);
         end
         push_byte(DIRECTED[i].data, DIRECTED[i].last);
      end

      phase = 0;
      while (items_sent < ITEM_TARGET + DIR_ROWS) begin
         pick = $urandom_range(0, 9);
         case (phase)
            0: tgt = 24'hFFFFFF;
            1: tgt = 24'd0;
            2: tgt = 24'h800000;
            default:
               tgt = (pick == 0) ? 24'd0 :
                     (pick == 1) ? 24'hFFFFFF :
                     (pick == 2) ? 24'($urandom) : 24'($urandom_range(1, 60));
         endcase
         settle();
         program_target(tgt);
         repeat ($urandom_range(3, 10)) send_text();
         phase++;
      end

      settle();
      repeat (8) @(posedge clock);
      if (pending_positions.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_positions.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("tb_utf8_offset_to_line_utf16_column_core: done, clean");
      else
         $display("tb_utf8_offset_to_line_utf16_column_core: done, errors");
      $finish;
   end

endmodule

[utf8_offset_to_line_utf16_column_core.f]
hdl/u8col_pkg.sv
hdl/u8col_step.sv
hdl/utf8_offset_to_line_utf16_column_core.sv
test/tb_utf8_offset_to_line_utf16_column_core.sv
